// File: src/stl_pkg.sv
`default_nettype none

package stl_pkg;

    // Default width of the column and token length counters
    localparam int COLUMN_BITS_DEFAULT = 16;

    // Width of the start column field on the result channel
    localparam int START_COL_W = 16;

    // Most results that one input transfer can cause
    localparam int MAX_RESULTS = 3;

    // Input kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_EOS  = 1'b1;

    // Result events
    typedef enum logic [1:0] {
        EV_CHAR    = 2'd0,
        EV_END     = 2'd1,
        EV_NEWLINE = 2'd2,
        EV_DONE    = 2'd3
    } event_t;

    // Lexer modes
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_COMMENT = 2'd1,
        MODE_STRING  = 2'd2
    } lex_mode_t;

    // Characters with special meaning
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_SEMI    = 8'h3B;

    // One result item
    typedef struct packed {
        event_t                   ev;
        logic [7:0]               token_char;
        logic                     is_string;
        logic [START_COL_W-1:0]   start_column;
    } result_t;

    // Results caused by one input transfer, in order from slot 0
    typedef struct packed {
        logic [1:0]                     count;
        result_t [MAX_RESULTS-1:0]      res;
    } bundle_t;

    function automatic result_t mk_result(event_t ev, logic [7:0] ch, logic str,
                                          logic [START_COL_W-1:0] col);
        result_t r;
        r.ev           = ev;
        r.token_char   = ch;
        r.is_string    = str;
        r.start_column = col;
        return r;
    endfunction

endpackage

`default_nettype wire

// File: src/scheme_token_lexer.sv
// scheme_token_lexer: Lisp s-expression tokenizer, one character per transfer.
//
// Input channel (s_*): tdata carries the character byte, tuser flags an
// end-of-stream mark. Output channel (m_*): one transfer per event (token
// character, token end with its type and start column, newline, stream
// finished); tlast marks the final event caused by one input transfer.
//
// Timing: the first event of an input appears on m_* in the cycle after the
// input transfer. An input causes zero to three events. Inputs with at most
// one event sustain one transfer per cycle while m_tready is high; an input
// with more events holds the output register until its last event leaves,
// when the next input is taken. The limit is the single output bundle register.
//
// Reset clears the mode, column and token length counters and empties the
// output register. When the receiver stalls, the pending event holds on m_*
// and s_tready stays low until the last event of the bundle is taken.
// End of stream ends any pending token and returns the lexer to reset state.

`default_nettype none

module scheme_token_lexer
    import stl_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] char_code
    input  wire logic [0:0]  s_tuser,   // [0] kind
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // [7:0] token_char, [23:8] start_column
    output logic [2:0]       m_tuser,   // [1:0] event_res, [2] is_string
    output logic             m_tlast
);

    lex_mode_t              mode_reg, mode_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;
    logic [COLUMN_BITS-1:0] len_reg, len_next;
    bundle_t                dec_bundle;
    result_t [MAX_RESULTS-1:0] res_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             idx_reg;
    logic                   busy;
    logic                   on_last;
    logic                   s_xfer;
    logic                   m_xfer;
    result_t                cur;

    stl_decode #(
        .COLUMN_BITS (COLUMN_BITS)
    ) u_decode (
        .kind      (s_tuser[0]),
        .char_code (s_tdata),
        .mode      (mode_reg),
        .col       (col_reg),
        .len       (len_reg),
        .mode_next (mode_next),
        .col_next  (col_next),
        .len_next  (len_next),
        .bundle    (dec_bundle)
    );

    // Handshake
    assign busy     = (cnt_reg != 2'd0);
    assign on_last  = (idx_reg == cnt_reg - 2'd1);
    assign s_tready = !busy || (m_tready && on_last);
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    // Present the current event
    assign cur      = res_reg[idx_reg];
    assign m_tvalid = busy;
    assign m_tdata  = {cur.start_column, cur.token_char};
    assign m_tuser  = {cur.is_string, cur.ev};
    assign m_tlast  = on_last;

    // Lexer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_NORMAL;
            col_reg  <= '0;
            len_reg  <= '0;
        end
        else if (s_xfer)
        begin
            mode_reg <= mode_next;
            col_reg  <= col_next;
            len_reg  <= len_next;
        end
    end

    // Output bundle: load on input transfer, advance on output transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            idx_reg <= 2'd0;
        end
        else if (s_xfer)
        begin
            cnt_reg <= dec_bundle.count;
            idx_reg <= 2'd0;
        end
        else if (m_xfer)
        begin
            // Empty the register once the last event leaves
            if (on_last)
            begin
                cnt_reg <= 2'd0;
                idx_reg <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Bundle payload
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            res_reg <= dec_bundle.res;
        end
    end

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (idx_reg < cnt_reg))
        else $error("result index beyond bundle count");

    a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[1:0] == EV_DONE) |-> m_tlast)
        else $error("stream finished event not last of its bundle");

    a_no_accept_mid_bundle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tlast) |-> !s_tready)
        else $error("input taken while bundle still has events");

    a_eos_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && s_tuser[0] == KIND_EOS) |=>
        (col_reg == '0 && len_reg == '0 && mode_reg == MODE_NORMAL))
        else $error("end of stream did not restore reset state");
`endif

endmodule

`default_nettype wire

// File: src/stl_decode.sv
`default_nettype none

module stl_decode
    import stl_pkg::*;
#(
    parameter int COLUMN_BITS = COLUMN_BITS_DEFAULT
) (
    input  wire logic                   kind,
    input  wire logic [7:0]             char_code,
    input  wire lex_mode_t              mode,
    input  wire logic [COLUMN_BITS-1:0] col,
    input  wire logic [COLUMN_BITS-1:0] len,
    output lex_mode_t                   mode_next,
    output logic [COLUMN_BITS-1:0]      col_next,
    output logic [COLUMN_BITS-1:0]      len_next,
    output bundle_t                     bundle
);

    localparam logic [COLUMN_BITS-1:0] ONE = COLUMN_BITS'(1);
    localparam logic [COLUMN_BITS-1:0] TWO = COLUMN_BITS'(2);

    logic [COLUMN_BITS-1:0] col_inc;
    logic [COLUMN_BITS-1:0] len_inc;
    logic [COLUMN_BITS-1:0] col_pend;
    logic [COLUMN_BITS-1:0] col_eos;
    logic [COLUMN_BITS-1:0] col_str;
    logic [COLUMN_BITS-1:0] col_one;
    logic                   pend;
    result_t                pend_end;
    logic [1:0]             n;

    function automatic logic [COLUMN_BITS-1:0] sat_inc(logic [COLUMN_BITS-1:0] v);
        return (v == '1) ? v : v + ONE;
    endfunction

    assign col_inc  = sat_inc(col);
    assign len_inc  = sat_inc(len);
    assign pend     = (len != '0);

    // Start columns wrap at the counter width
    assign col_pend = col_inc - len - ONE;
    assign col_eos  = col - len;
    assign col_str  = col_inc - len - TWO;
    assign col_one  = col_inc - ONE;

    assign pend_end = mk_result(EV_END, 8'd0, 1'b0, START_COL_W'(col_pend));

    // Work out next state and the ordered list of results
    always_comb
    begin
        bundle    = '0;
        n         = 2'd0;
        mode_next = mode;
        col_next  = col;
        len_next  = len;

        if (kind == KIND_EOS)
        begin
            // Close any pending token, finish the stream, return to reset state
            if (pend)
            begin
                bundle.res[n] = mk_result(EV_END, 8'd0, 1'b0, START_COL_W'(col_eos));
                n = n + 2'd1;
            end
            bundle.res[n] = mk_result(EV_DONE, 8'd0, 1'b0, '0);
            n = n + 2'd1;
            mode_next = MODE_NORMAL;
            col_next  = '0;
            len_next  = '0;
        end
        else if (mode == MODE_COMMENT && char_code != CH_NEWLINE)
        begin
            // Drop comment text
            col_next = col_inc;
        end
        else if (mode == MODE_STRING)
        begin
            col_next = col_inc;
            if (char_code == CH_DQUOTE)
            begin
                bundle.res[n] = mk_result(EV_END, 8'd0, 1'b1,
                                          START_COL_W'(col_str));
                n = n + 2'd1;
                len_next  = '0;
                mode_next = MODE_NORMAL;
            end
            else
            begin
                bundle.res[n] = mk_result(EV_CHAR, char_code, 1'b0, '0);
                n = n + 2'd1;
                len_next = len_inc;
            end
        end
        else
        begin
            col_next  = col_inc;
            mode_next = MODE_NORMAL;
            unique case (char_code) inside
                CH_LPAREN, CH_RPAREN, CH_QUOTE:
                begin
                    if (pend)
                    begin
                        bundle.res[n] = pend_end;
                        n = n + 2'd1;
                    end
                    bundle.res[n] = mk_result(EV_CHAR, char_code, 1'b0, '0);
                    n = n + 2'd1;
                    bundle.res[n] = mk_result(EV_END, 8'd0, 1'b0,
                                              START_COL_W'(col_one));
                    n = n + 2'd1;
                    len_next = '0;
                end
                CH_NEWLINE:
                begin
                    if (pend)
                    begin
                        bundle.res[n] = pend_end;
                        n = n + 2'd1;
                    end
                    bundle.res[n] = mk_result(EV_NEWLINE, 8'd0, 1'b0, '0);
                    n = n + 2'd1;
                    col_next = '0;
                    len_next = '0;
                end
                CH_SPACE, CH_DQUOTE:
                begin
                    if (pend)
                    begin
                        bundle.res[n] = pend_end;
                        n = n + 2'd1;
                    end
                    len_next = '0;
                    if (char_code == CH_DQUOTE)
                    begin
                        mode_next = MODE_STRING;
                    end
                end
                CH_SEMI:
                begin
                    mode_next = MODE_COMMENT;
                end
                default:
                begin
                    bundle.res[n] = mk_result(EV_CHAR, char_code, 1'b0, '0);
                    n = n + 2'd1;
                    len_next = len_inc;
                end
            endcase
        end

        bundle.count = n;
    end

endmodule

`default_nettype wire

// File: sim/tb_scheme_token_lexer.sv
`timescale 1ns / 1ps

module tb_scheme_token_lexer;
    import stl_pkg::*;

    localparam int COL_W = COLUMN_BITS_DEFAULT;
    localparam int DIR_LEN = 24;
    localparam int RAND_ITEMS = 180;
    localparam int LONG_TOKEN = 12;
    localparam int MAX_REPORTS = 10;

    // One expected event, with the last flag of its input transfer
    typedef struct packed {
        event_t                 ev;
        logic [7:0]             ch;
        logic                   str;
        logic [START_COL_W-1:0] col;
        logic                   last;
    } lex_event_t;

    typedef lex_event_t [MAX_RESULTS-1:0] event_set_t;

    // One row of the directed table; typed rows carry their events
    typedef struct {
        logic       kind;
        logic [7:0] ch;
        bit         typed;
        int         n;
        event_set_t evs;
    } dir_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] char_code
    logic [0:0]  s_tuser = 1'b0;    // [0] kind
    logic        m_tready = 1'b0;
    wire         s_tready;
    wire         m_tvalid;
    wire  [23:0] m_tdata;           // [7:0] token_char, [23:8] start_column
    wire  [2:0]  m_tuser;           // [1:0] event_res, [2] is_string
    wire         m_tlast;

    // Shadow lexer state
    lex_mode_t        lex_mode;
    logic [COL_W-1:0] col_cnt;
    logic [COL_W-1:0] tok_len;

    lex_event_t pending_events[$];
    dir_row_t   dir_tab[$];
    int         errors = 0;
    bit         quiet = 1'b0;
    int         stall_left = 0;
    lex_event_t got_ev;
    lex_event_t want_ev;

    scheme_token_lexer DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // Run the clock
    always #1 clk = ~clk;

    function automatic lex_event_t lex_ev(event_t e, logic [7:0] c, logic s,
                                          logic [START_COL_W-1:0] sc, logic lst);
        lex_event_t r;
        r.ev   = e;
        r.ch   = c;
        r.str  = s;
        r.col  = sc;
        r.last = lst;
        return r;
    endfunction

    function automatic dir_row_t mk_row(logic k, logic [7:0] c, bit typed, int n,
                                        lex_event_t e0, lex_event_t e1,
                                        lex_event_t e2);
        dir_row_t r;
        r.kind   = k;
        r.ch     = c;
        r.typed  = typed;
        r.n      = n;
        r.evs[0] = e0;
        r.evs[1] = e1;
        r.evs[2] = e2;
        return r;
    endfunction

    // End a pending normal token, start column measured from the column after increment
    function automatic void close_token(inout event_set_t evs, inout int n);
        if (tok_len != 0)
        begin
            evs[n] = lex_ev(EV_END, 8'h00, 1'b0, col_cnt - (tok_len + 1'b1), 1'b0);
            n = n + 1;
            tok_len = '0;
        end
    endfunction

    // Advance the shadow lexer by one input transfer and return its events
    function automatic int lex_step(input logic kind, input logic [7:0] ch,
                                    output event_set_t evs);
        int n;
        n = 0;
        evs = '0;
        if (kind == KIND_EOS)
        begin
            if (tok_len != 0)
            begin
                evs[n] = lex_ev(EV_END, 8'h00, 1'b0, col_cnt - tok_len, 1'b0);
                n = n + 1;
            end
            evs[n] = lex_ev(EV_DONE, 8'h00, 1'b0, '0, 1'b0);
            n = n + 1;
            lex_mode = MODE_NORMAL;
            col_cnt = '0;
            tok_len = '0;
        end
        else
        begin
            if (col_cnt != '1)
                col_cnt = col_cnt + 1'b1;
            if (lex_mode == MODE_COMMENT && ch != CH_NEWLINE)
            begin
                // drop commented characters
            end
            else if (lex_mode == MODE_STRING)
            begin
                if (ch == CH_DQUOTE)
                begin
                    evs[n] = lex_ev(EV_END, 8'h00, 1'b1, col_cnt - (tok_len + 2'd2), 1'b0);
                    n = n + 1;
                    tok_len = '0;
                    lex_mode = MODE_NORMAL;
                end
                else
                begin
                    evs[n] = lex_ev(EV_CHAR, ch, 1'b0, '0, 1'b0);
                    n = n + 1;
                    if (tok_len != '1)
                        tok_len = tok_len + 1'b1;
                end
            end
            else
            begin
                lex_mode = MODE_NORMAL;
                case (ch)
                    CH_LPAREN, CH_RPAREN, CH_QUOTE:
                    begin
                        close_token(evs, n);
                        evs[n] = lex_ev(EV_CHAR, ch, 1'b0, '0, 1'b0);
                        evs[n + 1] = lex_ev(EV_END, 8'h00, 1'b0, col_cnt - 1'b1, 1'b0);
                        n = n + 2;
                    end
                    CH_NEWLINE:
                    begin
                        close_token(evs, n);
                        col_cnt = '0;
                        evs[n] = lex_ev(EV_NEWLINE, 8'h00, 1'b0, '0, 1'b0);
                        n = n + 1;
                    end
                    CH_SPACE:
                        close_token(evs, n);
                    CH_DQUOTE:
                    begin
                        close_token(evs, n);
                        lex_mode = MODE_STRING;
                    end
                    CH_SEMI:
                        lex_mode = MODE_COMMENT;
                    default:
                    begin
                        evs[n] = lex_ev(EV_CHAR, ch, 1'b0, '0, 1'b0);
                        n = n + 1;
                        if (tok_len != '1)
                            tok_len = tok_len + 1'b1;
                    end
                endcase
            end
        end
        if (n > 0)
            evs[n - 1].last = 1'b1;
        return n;
    endfunction

    task automatic note_mismatch(input string what, input lex_event_t want,
                                 input lex_event_t got);
        errors = errors + 1;
        if (errors <= MAX_REPORTS)
        begin
            $display("%0t mismatch (%s): expected ev=%0d ch=%02h str=%0d col=%0d last=%0d",
                     $realtime, what, want.ev, want.ch, want.str, want.col, want.last);
            $display("    got ev=%0d ch=%02h str=%0d col=%0d last=%0d",
                     got.ev, got.ch, got.str, got.col, got.last);
        end
    endtask

    // Hand one item to the lexer and predict its events at the transfer
    task automatic put_item(input logic kind, input logic [7:0] ch, output int n,
                            output event_set_t evs);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= ch;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        n = lex_step(kind, ch, evs);
    endtask

    task automatic queue_events(input int n, input event_set_t evs);
        for (int i = 0; i < n; i++)
            pending_events.push_back(evs[i]);
    endtask

    // Pick a character weighted toward tokens and delimiters
    function automatic logic [7:0] pick_char();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return 8'($urandom_range(8'h61, 8'h7a));
        else if (sel < 40)
            return CH_SPACE;
        else if (sel < 48)
            return CH_LPAREN;
        else if (sel < 56)
            return CH_RPAREN;
        else if (sel < 60)
            return CH_QUOTE;
        else if (sel < 66)
            return CH_NEWLINE;
        else if (sel < 72)
            return CH_DQUOTE;
        else if (sel < 76)
            return CH_SEMI;
        else if (sel < 90)
            return 8'($urandom_range(0, 255));
        else
            return 8'($urandom_range(128, 255));
    endfunction

    // Stall the receiver in random bursts
    always @(posedge clk)
    begin
        if (quiet)
            m_tready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(1, 7) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Check each output transfer against the oldest expected event
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_ev.ev   = event_t'(m_tuser[1:0]);
            got_ev.ch   = m_tdata[7:0];
            got_ev.str  = m_tuser[2];
            got_ev.col  = m_tdata[23:8];
            got_ev.last = m_tlast;
            if (pending_events.size() == 0)
                note_mismatch("no event expected", '0, got_ev);
            else
            begin
                want_ev = pending_events.pop_front();
                if (got_ev !== want_ev)
                    note_mismatch("field", want_ev, got_ev);
            end
        end
    end

    // Bound the run
    initial
    begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        int         n;
        int         guard;
        event_set_t evs;
        logic       kind;
        logic [7:0] ch;

        lex_mode = MODE_NORMAL;
        col_cnt = '0;
        tok_len = '0;

        // Directed rows: reset state, extremes, brackets, strings, comments
        dir_tab.push_back(mk_row(KIND_EOS, 8'h00, 1'b1, 1,
            lex_ev(EV_DONE, 8'h00, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_LPAREN, 1'b1, 2,
            lex_ev(EV_CHAR, CH_LPAREN, 1'b0, 16'd0, 1'b0),
            lex_ev(EV_END, 8'h00, 1'b0, 16'd0, 1'b1), '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h61, 1'b1, 1,
            lex_ev(EV_CHAR, 8'h61, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'hFF, 1'b1, 1,
            lex_ev(EV_CHAR, 8'hFF, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_RPAREN, 1'b1, 3,
            lex_ev(EV_END, 8'h00, 1'b0, 16'd1, 1'b0),
            lex_ev(EV_CHAR, CH_RPAREN, 1'b0, 16'd0, 1'b0),
            lex_ev(EV_END, 8'h00, 1'b0, 16'd3, 1'b1)));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_SPACE, 1'b1, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h00, 1'b1, 1,
            lex_ev(EV_CHAR, 8'h00, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_NEWLINE, 1'b1, 2,
            lex_ev(EV_END, 8'h00, 1'b0, 16'd5, 1'b0),
            lex_ev(EV_NEWLINE, 8'h00, 1'b0, 16'd0, 1'b1), '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_DQUOTE, 1'b1, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_NEWLINE, 1'b1, 1,
            lex_ev(EV_CHAR, CH_NEWLINE, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_SEMI, 1'b1, 1,
            lex_ev(EV_CHAR, CH_SEMI, 1'b0, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_DQUOTE, 1'b1, 1,
            lex_ev(EV_END, 8'h00, 1'b1, 16'd0, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_DQUOTE, 1'b0, 0, '0, '0, '0));
        // empty string
        dir_tab.push_back(mk_row(KIND_CHAR, CH_DQUOTE, 1'b1, 1,
            lex_ev(EV_END, 8'h00, 1'b1, 16'd4, 1'b1), '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h78, 1'b0, 0, '0, '0, '0));
        // comment keeps the pending token
        dir_tab.push_back(mk_row(KIND_CHAR, CH_SEMI, 1'b0, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_LPAREN, 1'b1, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_NEWLINE, 1'b1, 2,
            lex_ev(EV_END, 8'h00, 1'b0, 16'd8, 1'b0),
            lex_ev(EV_NEWLINE, 8'h00, 1'b0, 16'd0, 1'b1), '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h71, 1'b0, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_QUOTE, 1'b1, 3,
            lex_ev(EV_END, 8'h00, 1'b0, 16'd0, 1'b0),
            lex_ev(EV_CHAR, CH_QUOTE, 1'b0, 16'd0, 1'b0),
            lex_ev(EV_END, 8'h00, 1'b0, 16'd1, 1'b1)));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h7A, 1'b0, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, CH_DQUOTE, 1'b0, 0, '0, '0, '0));
        dir_tab.push_back(mk_row(KIND_CHAR, 8'h6B, 1'b0, 0, '0, '0, '0));
        // unclosed string ends as a normal token
        dir_tab.push_back(mk_row(KIND_EOS, 8'hA5, 1'b1, 2,
            lex_ev(EV_END, 8'h00, 1'b0, 16'd4, 1'b0),
            lex_ev(EV_DONE, 8'h00, 1'b0, 16'd0, 1'b1), '0));

        // Hold reset, then release it
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table
        for (int i = 0; i < DIR_LEN; i++)
        begin
            put_item(dir_tab[i].kind, dir_tab[i].ch, n, evs);
            if (dir_tab[i].typed)
                queue_events(dir_tab[i].n, dir_tab[i].evs);
            else
                queue_events(n, evs);
        end

        // Random text, with calm stretches now and then
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            kind = ($urandom_range(0, 99) < 3) ? KIND_EOS : KIND_CHAR;
            ch = pick_char();
            put_item(kind, ch, n, evs);
            queue_events(n, evs);
        end

        // Finish with a long token and a short tail, no idling
        quiet = 1'b1;
        for (int i = 0; i < LONG_TOKEN; i++)
        begin
            put_item(KIND_CHAR, 8'($urandom_range(8'h61, 8'h7a)), n, evs);
            queue_events(n, evs);
        end
        put_item(KIND_CHAR, CH_RPAREN, n, evs);
        queue_events(n, evs);
        put_item(KIND_CHAR, CH_DQUOTE, n, evs);
        queue_events(n, evs);
        put_item(KIND_CHAR, 8'h62, n, evs);
        queue_events(n, evs);
        put_item(KIND_EOS, 8'h5A, n, evs);
        queue_events(n, evs);
        s_tvalid <= 1'b0;

        // Drain the remaining events
        guard = 0;
        while (pending_events.size() != 0 && guard < 20000)
        begin
            @(posedge clk);
            guard = guard + 1;
        end
        repeat (8) @(posedge clk);
        while (pending_events.size() != 0)
            note_mismatch("never arrived", pending_events.pop_front(), '0);

        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// File: sim.f
src/stl_pkg.sv
src/stl_decode.sv
src/scheme_token_lexer.sv
sim/tb_scheme_token_lexer.sv
